/* src/strip_fan_triangle_assembler_macros.svh */
// Assertion macros for the strip and fan triangle assembler checker.
// Depends on nothing; included by the checker file only.
`ifndef STRIP_FAN_TRIANGLE_ASSEMBLER_MACROS_SVH
`define STRIP_FAN_TRIANGLE_ASSEMBLER_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define SFA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("strip/fan assembler check failed");

// Next-cycle implication that stays live through reset.
`define SFA_ASSERT_NXT(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("strip/fan assembler check failed");

`endif

/* src/sfa_pkg.sv */
// Shared types and constants of the strip and fan triangle assembler.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps

package sfa_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 18;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MAX_COMMANDS,
    REG_MAX_VERTICES,
    REG_MAX_INDICES,
    REG_POSITION_COUNT,
    REG_NORMAL_COUNT,
    REG_EXPECTED_TRIANGLES
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_VERTEX,
    KIND_DONE,
    KIND_ERROR
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_BAD_COUNT,
    ERR_CMD_LIMIT,
    ERR_OUT_LIMIT,
    ERR_BAD_VERTEX,
    ERR_BAD_NORMAL,
    ERR_TRI_MISMATCH,
    ERR_ORDER
  } err_code_t;

  typedef struct packed {
    logic [15:0] max_commands;
    logic [15:0] max_vertices;
    logic [17:0] max_indices;
    logic [15:0] position_count;
    logic [15:0] normal_count;
    logic [16:0] expected_triangles;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    max_commands:       16'hFFFF,
    max_vertices:       16'hFFFF,
    max_indices:        18'h3FFFF,
    position_count:     16'h0000,
    normal_count:       16'h0000,
    expected_triangles: 17'h00000
  };

  typedef struct packed {
    kind_t              kind;
    logic [15:0]        vertex_number;
    logic [14:0]        position_ref;
    logic [14:0]        normal_ref;
    logic signed [15:0] out_s;
    logic signed [15:0] out_t;
    logic               has_triangle;
    logic [15:0]        tri_a;
    logic [15:0]        tri_b;
    logic [15:0]        tri_c;
    logic               degenerate;
    err_code_t          error_code;
  } result_t;

  // Positions of the edge components in the difference array.
  localparam int D_ABX = 0;
  localparam int D_ABY = 1;
  localparam int D_ABZ = 2;
  localparam int D_ACX = 3;
  localparam int D_ACY = 4;
  localparam int D_ACZ = 5;
  localparam int N_DIFF = 6;

endpackage

/* src/sfa_if.sv */
// Valid/ready channel interfaces for the input words and the result words.
// Depends on nothing.
`timescale 1ns / 1ps

interface sfa_in_if #(parameter int COORD_BITS = 24);
  logic                  valid;
  logic                  ready;
  logic                  func;
  logic signed [15:0]    count;
  logic signed [15:0]    vtx_idx;
  logic signed [15:0]    nrm_idx;
  logic signed [15:0]    tex_s;
  logic signed [15:0]    tex_t;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;
  logic signed [COORD_BITS-1:0] pos_z;

  modport source (output valid, func, count, vtx_idx, nrm_idx, tex_s, tex_t,
                  pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, func, count, vtx_idx, nrm_idx, tex_s, tex_t,
                pos_x, pos_y, pos_z, output ready);
endinterface

interface sfa_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [15:0]        vertex_number;
  logic [14:0]        position_ref;
  logic [14:0]        normal_ref;
  logic signed [15:0] out_s;
  logic signed [15:0] out_t;
  logic               has_triangle;
  logic [15:0]        tri_a;
  logic [15:0]        tri_b;
  logic [15:0]        tri_c;
  logic               degenerate;
  logic [2:0]         error_code;

  modport source (output valid, kind, vertex_number, position_ref, normal_ref, out_s, out_t,
                  has_triangle, tri_a, tri_b, tri_c, degenerate, error_code, input ready);
  modport sink (input valid, kind, vertex_number, position_ref, normal_ref, out_s, out_t,
                has_triangle, tri_a, tri_b, tri_c, degenerate, error_code, output ready);
endinterface

/* src/strip_fan_triangle_assembler.sv */
// Top level of the strip and fan to triangle list assembler.
// Depends on sfa_pkg, sfa_if, sfa_cfg, sfa_ctrl and sfa_cross.
//
//   channel   role     contents
//   items     sink     command headers and vertex records
//   results   source   vertex results, stream done, error words
//   cfg_*     write    limits, source counts, expected triangle total
//
// One item is accepted per cycle while the stages are not stalled by results.ready.
// The three stages are the control stage, the product stage and the output register.
// Headers that open a command give no result and leave a bubble that later stalls absorb.
// Items are refused only while all three stages hold results and results.ready is low.
// Reset is synchronous and clears the stream state, the stage valids and the configuration registers.
`timescale 1ns / 1ps

module strip_fan_triangle_assembler #(
  parameter int COORD_BITS = 24
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [sfa_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sfa_pkg::CFG_DATA_W-1:0]  cfg_data,
  sfa_in_if.sink                          items,
  sfa_out_if.source                       results
);
  import sfa_pkg::*;

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;

  cfg_t    cfg;
  result_t res0, rec1, rec2, rec3;
  result_t rec3_next;
  logic    has_res0;
  logic    accept;
  logic    v1, v2, v3;
  logic    ld1, ld2, ld3;
  logic    zero_area;

  logic signed [DW-1:0] diff0 [N_DIFF];
  logic signed [DW-1:0] diff1 [N_DIFF];
  logic signed [PW-1:0] prod2 [N_DIFF];

  sfa_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sfa_ctrl #(.COORD_BITS(COORD_BITS)) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .cfg          (cfg),
    .func         (items.func),
    .count        (items.count),
    .vtx_idx      (items.vtx_idx),
    .nrm_idx      (items.nrm_idx),
    .tex_s        (items.tex_s),
    .tex_t        (items.tex_t),
    .pos_x        (items.pos_x),
    .pos_y        (items.pos_y),
    .pos_z        (items.pos_z),
    .res          (res0),
    .has_res      (has_res0),
    .diff         (diff0)
  );

  sfa_cross #(.COORD_BITS(COORD_BITS)) u_cross (
    .clk  (clk),
    .ld   (ld2),
    .diff (diff1),
    .prod (prod2)
  );

  // Each stage loads when it is empty or the stage after it is moving.
  assign ld3 = !v3 || results.ready;
  assign ld2 = !v2 || ld3;
  assign ld1 = !v1 || ld2;
  assign items.ready = ld1;
  assign accept = items.valid && ld1;

  assign zero_area = (prod2[0] == prod2[1]) && (prod2[2] == prod2[3]) &&
                     (prod2[4] == prod2[5]);

  always_comb begin
    rec3_next = rec2;
    rec3_next.degenerate = rec2.has_triangle && (rec2.degenerate || zero_area);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ld1) begin
        v1 <= accept && has_res0;
      end
      if (ld2) begin
        v2 <= v1;
      end
      if (ld3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      rec1 <= res0;
      diff1 <= diff0;
    end
    if (ld2) begin
      rec2 <= rec1;
    end
    if (ld3) begin
      rec3 <= rec3_next;
    end
  end

  assign results.valid         = v3;
  assign results.kind          = rec3.kind;
  assign results.vertex_number = rec3.vertex_number;
  assign results.position_ref  = rec3.position_ref;
  assign results.normal_ref    = rec3.normal_ref;
  assign results.out_s         = rec3.out_s;
  assign results.out_t         = rec3.out_t;
  assign results.has_triangle  = rec3.has_triangle;
  assign results.tri_a         = rec3.tri_a;
  assign results.tri_b         = rec3.tri_b;
  assign results.tri_c         = rec3.tri_c;
  assign results.degenerate    = rec3.degenerate;
  assign results.error_code    = rec3.error_code;

endmodule

/* src/sfa_cfg.sv */
// Configuration register file of the assembler: limits, counts, expected total.
// Depends on sfa_pkg.
`timescale 1ns / 1ps

module sfa_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [sfa_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [sfa_pkg::CFG_DATA_W-1:0]   cfg_data,
  output sfa_pkg::cfg_t                    cfg
);
  import sfa_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_MAX_COMMANDS:       cfg.max_commands       <= cfg_data[15:0];
        REG_MAX_VERTICES:       cfg.max_vertices       <= cfg_data[15:0];
        REG_MAX_INDICES:        cfg.max_indices        <= cfg_data[17:0];
        REG_POSITION_COUNT:     cfg.position_count     <= cfg_data[15:0];
        REG_NORMAL_COUNT:       cfg.normal_count       <= cfg_data[15:0];
        REG_EXPECTED_TRIANGLES: cfg.expected_triangles <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

endmodule

/* src/sfa_ctrl.sv */
// Stream control: header checks, vertex numbering, triangle indices and the
// two held vertices. Produces the result word and the edge vectors. Uses sfa_pkg.
`timescale 1ns / 1ps

module sfa_ctrl #(
  parameter int COORD_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  sfa_pkg::cfg_t                 cfg,
  input  logic                          func,
  input  logic signed [15:0]            count,
  input  logic signed [15:0]            vtx_idx,
  input  logic signed [15:0]            nrm_idx,
  input  logic signed [15:0]            tex_s,
  input  logic signed [15:0]            tex_t,
  input  logic signed [COORD_BITS-1:0]  pos_x,
  input  logic signed [COORD_BITS-1:0]  pos_y,
  input  logic signed [COORD_BITS-1:0]  pos_z,
  output sfa_pkg::result_t              res,
  output logic                          has_res,
  output logic signed [COORD_BITS:0]    diff [sfa_pkg::N_DIFF]
);
  import sfa_pkg::*;

  localparam int DW = COORD_BITS + 1;

  typedef struct packed {
    logic        in_command;
    logic        fan_mode;
    logic [14:0] command_length;
    logic [14:0] ordinal;
    logic [15:0] base_vertex;
    logic [15:0] vertices_emitted;
    logic [17:0] indices_used;
    logic [16:0] triangles_total;
    logic [15:0] commands_seen;
  } stream_t;

  stream_t st, st_next;

  logic [14:0]                  hsrc [2];
  logic signed [COORD_BITS-1:0] hx [2];
  logic signed [COORD_BITS-1:0] hy [2];
  logic signed [COORD_BITS-1:0] hz [2];

  logic        held_we;
  logic        fail;
  err_code_t   code;
  logic        vi_ok, ni_ok, cnt_min, cmd_lim, vc_small, over_v, over_i;
  logic [15:0] neg_count;
  logic [14:0] vc, tris;
  logic [16:0] tri3;
  logic [15:0] vfree;
  logic [17:0] ifree;
  logic [14:0] src;
  logic        idx_deg, has_tri;
  logic [14:0] ord_m1, ord_m2, ord_p1, ra, rb;

  assign vi_ok = !vtx_idx[15] && ({1'b0, vtx_idx[14:0]} < cfg.position_count);
  assign ni_ok = !nrm_idx[15] && ({1'b0, nrm_idx[14:0]} < cfg.normal_count);
  assign cnt_min = (count == 16'sh8000);
  assign cmd_lim = (st.commands_seen >= cfg.max_commands);
  assign neg_count = -count;
  assign vc = count[15] ? neg_count[14:0] : count[14:0];
  assign vc_small = (vc < 15'd3);
  assign vfree = cfg.max_vertices - ((st.vertices_emitted < cfg.max_vertices) ?
                                     st.vertices_emitted : cfg.max_vertices);
  assign ifree = cfg.max_indices - ((st.indices_used < cfg.max_indices) ?
                                    st.indices_used : cfg.max_indices);
  assign tris = vc - 15'd2;
  // Comparing against three times the triangle count avoids dividing the free slots by 3.
  assign tri3 = {2'b00, tris} + {1'b0, tris, 1'b0};
  assign over_v = ({1'b0, vc} > vfree);
  assign over_i = (ifree < {1'b0, tri3});

  assign src = vtx_idx[14:0];
  assign idx_deg = (hsrc[0] == hsrc[1]) || (hsrc[1] == src) || (hsrc[0] == src);
  assign has_tri = (st.ordinal >= 15'd2);
  assign ord_m1 = st.ordinal - 15'd1;
  assign ord_m2 = st.ordinal - 15'd2;
  assign ord_p1 = st.ordinal + 15'd1;
  // Strips swap the first two corners on odd ordinals to keep the winding.
  assign ra = st.fan_mode ? 15'd0 : (st.ordinal[0] ? ord_m1 : ord_m2);
  assign rb = st.fan_mode ? ord_m1 : (st.ordinal[0] ? ord_m2 : ord_m1);

  always_comb begin
    st_next = st;
    res = '0;
    has_res = 1'b0;
    held_we = 1'b0;
    fail = 1'b0;
    code = ERR_NONE;
    if (!func) begin
      if (st.in_command) begin
        fail = 1'b1;
        code = ERR_ORDER;
      end else if (count == 16'sd0) begin
        has_res = 1'b1;
        st_next = '0;
        if (st.triangles_total != cfg.expected_triangles) begin
          res.kind = KIND_ERROR;
          res.error_code = ERR_TRI_MISMATCH;
        end else begin
          res.kind = KIND_DONE;
        end
      end else if (cnt_min) begin
        fail = 1'b1;
        code = ERR_BAD_COUNT;
      end else if (cmd_lim) begin
        fail = 1'b1;
        code = ERR_CMD_LIMIT;
      end else if (vc_small) begin
        fail = 1'b1;
        code = ERR_BAD_COUNT;
      end else if (over_v || over_i) begin
        fail = 1'b1;
        code = ERR_OUT_LIMIT;
      end else begin
        st_next.in_command = 1'b1;
        st_next.fan_mode = count[15];
        st_next.command_length = vc;
        st_next.ordinal = '0;
        st_next.base_vertex = st.vertices_emitted;
        st_next.commands_seen = st.commands_seen + 16'd1;
      end
    end else begin
      if (!st.in_command) begin
        fail = 1'b1;
        code = ERR_ORDER;
      end else if (!vi_ok) begin
        fail = 1'b1;
        code = ERR_BAD_VERTEX;
      end else if (!ni_ok) begin
        fail = 1'b1;
        code = ERR_BAD_NORMAL;
      end else begin
        has_res = 1'b1;
        held_we = 1'b1;
        res.kind = KIND_VERTEX;
        res.vertex_number = st.vertices_emitted;
        res.position_ref = src;
        res.normal_ref = nrm_idx[14:0];
        res.out_s = tex_s;
        res.out_t = tex_t;
        if (has_tri) begin
          res.has_triangle = 1'b1;
          res.tri_a = st.base_vertex + {1'b0, ra};
          res.tri_b = st.base_vertex + {1'b0, rb};
          res.tri_c = st.base_vertex + {1'b0, st.ordinal};
          // Zero area is folded in later, once the cross products are ready.
          res.degenerate = idx_deg;
          st_next.triangles_total = st.triangles_total + 17'd1;
          st_next.indices_used = st.indices_used + 18'd3;
        end
        st_next.vertices_emitted = st.vertices_emitted + 16'd1;
        st_next.ordinal = ord_p1;
        if (ord_p1 >= st.command_length) begin
          st_next.in_command = 1'b0;
        end
      end
    end
    if (fail) begin
      has_res = 1'b1;
      res = '0;
      res.kind = KIND_ERROR;
      res.error_code = code;
      st_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (accept) begin
      st <= st_next;
    end
  end

  // Held vertices are only read once both slots of the current command are written.
  always_ff @(posedge clk) begin
    if (accept && held_we) begin
      if (has_tri) begin
        if (!st.fan_mode) begin
          hsrc[0] <= hsrc[1];
          hx[0] <= hx[1];
          hy[0] <= hy[1];
          hz[0] <= hz[1];
        end
        hsrc[1] <= src;
        hx[1] <= pos_x;
        hy[1] <= pos_y;
        hz[1] <= pos_z;
      end else begin
        hsrc[st.ordinal[0]] <= src;
        hx[st.ordinal[0]] <= pos_x;
        hy[st.ordinal[0]] <= pos_y;
        hz[st.ordinal[0]] <= pos_z;
      end
    end
  end

  assign diff[D_ABX] = DW'(hx[1]) - DW'(hx[0]);
  assign diff[D_ABY] = DW'(hy[1]) - DW'(hy[0]);
  assign diff[D_ABZ] = DW'(hz[1]) - DW'(hz[0]);
  assign diff[D_ACX] = DW'(pos_x) - DW'(hx[0]);
  assign diff[D_ACY] = DW'(pos_y) - DW'(hy[0]);
  assign diff[D_ACZ] = DW'(pos_z) - DW'(hz[0]);

endmodule

/* src/sfa_cross.sv */
// Registered products of the cross-product terms of one triangle.
// Depends on sfa_pkg for the edge component positions.
`timescale 1ns / 1ps

module sfa_cross #(
  parameter int COORD_BITS = 24
) (
  input  logic                             clk,
  input  logic                             ld,
  input  logic signed [COORD_BITS:0]       diff [sfa_pkg::N_DIFF],
  output logic signed [2*COORD_BITS+1:0]   prod [sfa_pkg::N_DIFF]
);
  import sfa_pkg::*;

  // Each axis of the cross product is zero exactly when its pair of products match.
  always_ff @(posedge clk) begin
    if (ld) begin
      prod[0] <= diff[D_ABY] * diff[D_ACZ];
      prod[1] <= diff[D_ABZ] * diff[D_ACY];
      prod[2] <= diff[D_ABZ] * diff[D_ACX];
      prod[3] <= diff[D_ABX] * diff[D_ACZ];
      prod[4] <= diff[D_ABX] * diff[D_ACY];
      prod[5] <= diff[D_ABY] * diff[D_ACX];
    end
  end

endmodule

/* src/sfa_checker.sv */
// Port-level checks of the assembler, attached to the top level by bind.
// Depends on sfa_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "strip_fan_triangle_assembler_macros.svh"

module sfa_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  kind,
  input logic [15:0] vertex_number,
  input logic        has_triangle,
  input logic [15:0] tri_c,
  input logic [2:0]  error_code
);
  import sfa_pkg::*;

  // A word that is held back keeps its valid, its kind and its vertex number.
  `SFA_ASSERT_NXT(a_hold_valid, clk, (!rst && out_valid && !out_ready), (rst || out_valid))
  `SFA_ASSERT_NXT(a_hold_word, clk, (!rst && out_valid && !out_ready), (rst || ($stable(kind) && $stable(vertex_number))))
  // Reset empties the output register in the same edge.
  `SFA_ASSERT_NXT(a_reset_empty, clk, rst, !out_valid)
  // The completing corner of a triangle is always the vertex just numbered.
  `SFA_ASSERT_IMP(a_tri_last, clk, rst, (out_valid && has_triangle), (tri_c == vertex_number && kind == KIND_VERTEX && error_code == ERR_NONE))

endmodule

bind strip_fan_triangle_assembler sfa_checker u_sfa_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (results.valid),
  .out_ready     (results.ready),
  .kind          (results.kind),
  .vertex_number (results.vertex_number),
  .has_triangle  (results.has_triangle),
  .tri_c         (results.tri_c),
  .error_code    (results.error_code)
);

/* bench/sfa_assembly_checker.sv */
// Watches the item, result and register ports of the strip and fan assembler,
// predicts every result word and compares it with what the block returns.
// Depends on sfa_pkg and the channel interfaces in sfa_if.
`timescale 1ns / 1ps

module sfa_assembly_checker
  import sfa_pkg::*;
#(
  parameter int COORD_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  sfa_in_if                      items,
  sfa_out_if                     results,
  output int                     mismatches,
  output int                     pending
);

  localparam logic signed [15:0] COUNT_MIN = 16'sh8000;

  cfg_t regs;

  bit                          in_cmd;
  bit                          fan;
  logic [14:0]                 cmd_len;
  logic [14:0]                 ordn;
  logic [15:0]                 base_v;
  logic [15:0]                 v_emitted;
  logic [15:0]                 cmds_seen;
  logic [17:0]                 idx_used;
  logic [16:0]                 tri_total;
  logic [14:0]                 held_src [2];
  logic signed [COORD_BITS-1:0] held_x [2];
  logic signed [COORD_BITS-1:0] held_y [2];
  logic signed [COORD_BITS-1:0] held_z [2];

  result_t predicted_words[$];

  function automatic void clear_stream();
    in_cmd    = 1'b0;
    fan       = 1'b0;
    cmd_len   = '0;
    ordn      = '0;
    base_v    = '0;
    v_emitted = '0;
    idx_used  = '0;
    tri_total = '0;
    cmds_seen = '0;
    for (int i = 0; i < 2; i++) begin
      held_src[i] = '0;
      held_x[i]   = '0;
      held_y[i]   = '0;
      held_z[i]   = '0;
    end
  endfunction

  // A finished stream and every error give one status word and drop the stream.
  function automatic bit close_stream(output result_t r, input kind_t k, input err_code_t e);
    r            = '0;
    r.kind       = k;
    r.error_code = e;
    clear_stream();
    return 1'b1;
  endfunction

  function automatic void apply_reg(input logic [CFG_INDEX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_MAX_COMMANDS:       regs.max_commands       = val[15:0];
      REG_MAX_VERTICES:       regs.max_vertices       = val[15:0];
      REG_MAX_INDICES:        regs.max_indices        = val[17:0];
      REG_POSITION_COUNT:     regs.position_count     = val[15:0];
      REG_NORMAL_COUNT:       regs.normal_count       = val[15:0];
      REG_EXPECTED_TRIANGLES: regs.expected_triangles = val[16:0];
      default: ;
    endcase
  endfunction

  // Returns 1 when the item produces a result word, which is left in r.
  function automatic bit assemble_item(input logic func,
                                       input logic signed [15:0] cnt,
                                       input logic signed [15:0] vi,
                                       input logic signed [15:0] ni,
                                       input logic signed [15:0] s,
                                       input logic signed [15:0] t,
                                       input logic signed [COORD_BITS-1:0] x,
                                       input logic signed [COORD_BITS-1:0] y,
                                       input logic signed [COORD_BITS-1:0] z,
                                       output result_t r);
    int          vc;
    int          vfree;
    int          ifree;
    logic [14:0] ra;
    logic [14:0] rb;
    logic [14:0] src;
    longint      abx, aby, abz, acx, acy, acz;
    bit          deg;
    r = '0;
    if (!func) begin
      if (in_cmd) return close_stream(r, KIND_ERROR, ERR_ORDER);
      if (cnt == 0) begin
        if (tri_total != regs.expected_triangles)
          return close_stream(r, KIND_ERROR, ERR_TRI_MISMATCH);
        return close_stream(r, KIND_DONE, ERR_NONE);
      end
      if (cnt == COUNT_MIN) return close_stream(r, KIND_ERROR, ERR_BAD_COUNT);
      if (cmds_seen >= regs.max_commands) return close_stream(r, KIND_ERROR, ERR_CMD_LIMIT);
      vc = (cnt < 0) ? -int'(cnt) : int'(cnt);
      if (vc < 3) return close_stream(r, KIND_ERROR, ERR_BAD_COUNT);
      vfree = int'(regs.max_vertices) -
              ((v_emitted < regs.max_vertices) ? int'(v_emitted) : int'(regs.max_vertices));
      if (vc > vfree) return close_stream(r, KIND_ERROR, ERR_OUT_LIMIT);
      ifree = int'(regs.max_indices) -
              ((idx_used < regs.max_indices) ? int'(idx_used) : int'(regs.max_indices));
      if (vc - 2 > ifree / 3) return close_stream(r, KIND_ERROR, ERR_OUT_LIMIT);
      in_cmd    = 1'b1;
      fan       = (cnt < 0);
      cmd_len   = 15'(vc);
      ordn      = '0;
      base_v    = v_emitted;
      cmds_seen = cmds_seen + 16'd1;
      return 1'b0;
    end

    if (!in_cmd) return close_stream(r, KIND_ERROR, ERR_ORDER);
    if (vi < 0 || int'(vi) >= int'(regs.position_count))
      return close_stream(r, KIND_ERROR, ERR_BAD_VERTEX);
    if (ni < 0 || int'(ni) >= int'(regs.normal_count))
      return close_stream(r, KIND_ERROR, ERR_BAD_NORMAL);
    src             = vi[14:0];
    r.kind          = KIND_VERTEX;
    r.vertex_number = v_emitted;
    r.position_ref  = src;
    r.normal_ref    = ni[14:0];
    r.out_s         = s;
    r.out_t         = t;
    if (ordn >= 15'd2) begin
      // Fans pivot on the first vertex; strips swap the first two on odd vertices.
      if (fan) begin
        ra = '0;
        rb = ordn - 15'd1;
      end else if (!ordn[0]) begin
        ra = ordn - 15'd2;
        rb = ordn - 15'd1;
      end else begin
        ra = ordn - 15'd1;
        rb = ordn - 15'd2;
      end
      deg = (held_src[0] == held_src[1]) || (held_src[1] == src) || (held_src[0] == src);
      abx = longint'(held_x[1]) - longint'(held_x[0]);
      aby = longint'(held_y[1]) - longint'(held_y[0]);
      abz = longint'(held_z[1]) - longint'(held_z[0]);
      acx = longint'(x) - longint'(held_x[0]);
      acy = longint'(y) - longint'(held_y[0]);
      acz = longint'(z) - longint'(held_z[0]);
      if (aby * acz == abz * acy && abz * acx == abx * acz && abx * acy == aby * acx)
        deg = 1'b1;
      r.has_triangle = 1'b1;
      r.tri_a        = base_v + {1'b0, ra};
      r.tri_b        = base_v + {1'b0, rb};
      r.tri_c        = base_v + {1'b0, ordn};
      r.degenerate   = deg;
      tri_total      = tri_total + 17'd1;
      idx_used       = idx_used + 18'd3;
      if (!fan) begin
        held_src[0] = held_src[1];
        held_x[0]   = held_x[1];
        held_y[0]   = held_y[1];
        held_z[0]   = held_z[1];
      end
      held_src[1] = src;
      held_x[1]   = x;
      held_y[1]   = y;
      held_z[1]   = z;
    end else begin
      held_src[ordn[0]] = src;
      held_x[ordn[0]]   = x;
      held_y[ordn[0]]   = y;
      held_z[ordn[0]]   = z;
    end
    v_emitted = v_emitted + 16'd1;
    ordn      = ordn + 15'd1;
    if (ordn >= cmd_len) in_cmd = 1'b0;
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    result_t got;
    if (rst) begin
      regs = CFG_RESET;
      clear_stream();
      predicted_words.delete();
      mismatches = 0;
    end else begin
      if (results.valid && results.ready) begin
        if (predicted_words.size() == 0) begin
          $error("result word arrived with no prediction waiting");
          mismatches++;
        end else begin
          want = predicted_words.pop_front();
          check_field("kind", want.kind, results.kind);
          check_field("vertex_number", want.vertex_number, results.vertex_number);
          check_field("position_ref", want.position_ref, results.position_ref);
          check_field("normal_ref", want.normal_ref, results.normal_ref);
          check_field("out_s", want.out_s, results.out_s);
          check_field("out_t", want.out_t, results.out_t);
          check_field("has_triangle", want.has_triangle, results.has_triangle);
          check_field("tri_a", want.tri_a, results.tri_a);
          check_field("tri_b", want.tri_b, results.tri_b);
          check_field("tri_c", want.tri_c, results.tri_c);
          check_field("degenerate", want.degenerate, results.degenerate);
          check_field("error_code", want.error_code, results.error_code);
        end
      end
      if (items.valid && items.ready) begin
        if (assemble_item(items.func, items.count, items.vtx_idx, items.nrm_idx,
                          items.tex_s, items.tex_t, items.pos_x, items.pos_y, items.pos_z,
                          got))
          predicted_words.insert(predicted_words.size(), got);
      end
      if (cfg_we) apply_reg(cfg_index, cfg_data);
    end
    pending = predicted_words.size();
  end

endmodule

/* bench/tb_strip_fan_triangle_assembler.sv */
// Top of the strip and fan assembler bench: clock, reset, register writes and
// item stimulus; the checker beside the block predicts and compares results.
// Depends on sfa_pkg, sfa_if, the block and sfa_assembly_checker.
`timescale 1ns / 1ps

module tb_strip_fan_triangle_assembler;
  import sfa_pkg::*;

  localparam int XW           = 24;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int LIMIT_CYCLES = 400000;

  typedef struct packed {
    logic                 func;
    logic signed [15:0]   count;
    logic signed [15:0]   vtx_idx;
    logic signed [15:0]   nrm_idx;
    logic signed [15:0]   tex_s;
    logic signed [15:0]   tex_t;
    logic signed [XW-1:0] pos_x;
    logic signed [XW-1:0] pos_y;
    logic signed [XW-1:0] pos_z;
  } item_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   hold_start;
  int                     send_pct;
  int                     stall_pct;
  int                     mismatches;
  int                     pending;
  cfg_t                   cur_cfg;
  logic signed [XW-1:0]   prev_x, prev_y, prev_z;

  sfa_in_if #(.COORD_BITS(XW)) items ();
  sfa_out_if                   results ();

  strip_fan_triangle_assembler #(.COORD_BITS(XW)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .items     (items),
    .results   (results)
  );

  sfa_assembly_checker #(.COORD_BITS(XW)) u_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .items      (items),
    .results    (results),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always #6 clk = ~clk;

  function automatic cfg_t make_cfg(input int mc, input int mv, input int mi,
                                    input int pc, input int nc, input int et);
    cfg_t c;
    c.max_commands       = 16'(mc);
    c.max_vertices       = 16'(mv);
    c.max_indices        = 18'(mi);
    c.position_count     = 16'(pc);
    c.normal_count       = 16'(nc);
    c.expected_triangles = 17'(et);
    return c;
  endfunction

  function automatic item_t random_item();
    item_t w;
    w.func    = 1'($urandom);
    w.count   = 16'($urandom);
    w.vtx_idx = 16'($urandom);
    w.nrm_idx = 16'($urandom);
    w.tex_s   = 16'($urandom);
    w.tex_t   = 16'($urandom);
    w.pos_x   = XW'($urandom);
    w.pos_y   = XW'($urandom);
    w.pos_z   = XW'($urandom);
    return w;
  endfunction

  function automatic item_t hdr(input int c);
    item_t w;
    w       = '0;
    w.count = 16'(c);
    return w;
  endfunction

  function automatic item_t vtx(input int vi, input int ni, input int s, input int t,
                                input int x, input int y, input int z);
    item_t w;
    w         = '0;
    w.func    = 1'b1;
    w.vtx_idx = 16'(vi);
    w.nrm_idx = 16'(ni);
    w.tex_s   = 16'(s);
    w.tex_t   = 16'(t);
    w.pos_x   = XW'(x);
    w.pos_y   = XW'(y);
    w.pos_z   = XW'(z);
    return w;
  endfunction

  // Mostly legal indices; positions shaped so that zero-area triangles are common.
  function automatic item_t vertex_word(input cfg_t c);
    item_t    w;
    int       pc;
    int       nc;
    bit [2:0] sgn;
    w   = random_item();
    sgn = 3'($urandom);
    w.func = 1'b1;
    pc = (c.position_count > 16'd32768) ? 32768 : int'(c.position_count);
    nc = (c.normal_count > 16'd32768) ? 32768 : int'(c.normal_count);
    if (pc > 0 && $urandom_range(99) < 97) w.vtx_idx = 16'($urandom_range(pc - 1));
    if (nc > 0 && $urandom_range(99) < 98) w.nrm_idx = 16'($urandom_range(nc - 1));
    case ($urandom_range(9))
      0: begin
        w.pos_x = prev_x;
        w.pos_y = prev_y;
        w.pos_z = prev_z;
      end
      1, 2: begin
        w.pos_x = XW'(int'($urandom_range(4)) - 2);
        w.pos_y = XW'(int'($urandom_range(4)) - 2);
        w.pos_z = XW'(int'($urandom_range(4)) - 2);
      end
      3: begin
        w.pos_x = {sgn[0], {(XW-1){~sgn[0]}}};
        w.pos_y = {sgn[1], {(XW-1){~sgn[1]}}};
        w.pos_z = {sgn[2], {(XW-1){~sgn[2]}}};
      end
      default: ;
    endcase
    prev_x = w.pos_x;
    prev_y = w.pos_y;
    prev_z = w.pos_z;
    return w;
  endfunction

  // Called right after a rising edge; returns right after the edge that took the word.
  task automatic send_word(input item_t w);
    bit ok;
    while ($urandom_range(99) < send_pct) begin
      items.valid <= 1'b0;
      @(posedge clk);
    end
    items.valid   <= 1'b1;
    items.func    <= w.func;
    items.count   <= w.count;
    items.vtx_idx <= w.vtx_idx;
    items.nrm_idx <= w.nrm_idx;
    items.tex_s   <= w.tex_s;
    items.tex_t   <= w.tex_t;
    items.pos_x   <= w.pos_x;
    items.pos_y   <= w.pos_y;
    items.pos_z   <= w.pos_z;
    do begin
      @(negedge clk);
      ok = items.ready;
      @(posedge clk);
    end while (!ok);
  endtask

  task automatic put_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic write_config(input cfg_t c);
    cfg_we <= 1'b1;
    put_reg(REG_MAX_COMMANDS, 18'(c.max_commands));
    put_reg(REG_MAX_VERTICES, 18'(c.max_vertices));
    put_reg(REG_MAX_INDICES, c.max_indices);
    put_reg(REG_POSITION_COUNT, 18'(c.position_count));
    put_reg(REG_NORMAL_COUNT, 18'(c.normal_count));
    put_reg(REG_EXPECTED_TRIANGLES, 18'(c.expected_triangles));
    cfg_we  <= 1'b0;
    cur_cfg = c;
  endtask

  // Opening headers leave no result behind, so the task still waits after the last result is taken.
  task automatic settle();
    items.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Streams of strips and fans that add up to stream_tris triangles, with some noise,
  // cut-short commands and missing end headers mixed in.
  task automatic run_random(input int n_items, input int stream_tris);
    int sent;
    int left;
    int t;
    int len;
    bit fan;
    sent = 0;
    while (sent < n_items) begin
      left = stream_tris;
      while (left > 0 && sent < n_items) begin
        if ($urandom_range(99) < 4) begin
          send_word(random_item());
          sent++;
        end
        t   = $urandom_range((left < 6) ? left : 6, 1);
        fan = 1'($urandom);
        len = t + 2;
        send_word(hdr(fan ? -len : len));
        sent++;
        if ($urandom_range(99) < 3) len = $urandom_range(len - 1);
        repeat (len) begin
          send_word(vertex_word(cur_cfg));
          sent++;
        end
        left -= t;
      end
      if ($urandom_range(99) < 92) begin
        send_word(hdr(0));
        sent++;
      end
    end
  endtask

  task automatic run_phase(input cfg_t c, input int sp, input int rp, input int n_items,
                           input int stream_tris, input bit long_hold);
    write_config(c);
    send_pct  = sp;
    stall_pct <= rp;
    if (long_hold) begin
      hold_start <= 1'b1;
      @(posedge clk);
      hold_start <= 1'b0;
    end
    run_random(n_items, stream_tris);
    settle();
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin : receiver
    int hold_left;
    hold_left     = 0;
    results.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        results.ready <= 1'b0;
      end else if (hold_start) begin
        hold_left     = HOLD_CYCLES;
        results.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        results.ready <= 1'b0;
      end else begin
        results.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    hold_start    = 1'b0;
    send_pct      = 0;
    stall_pct     = 0;
    prev_x        = '0;
    prev_y        = '0;
    prev_z        = '0;
    cur_cfg       = CFG_RESET;
    items.valid   = 1'b0;
    items.func    = 1'b0;
    items.count   = '0;
    items.vtx_idx = '0;
    items.nrm_idx = '0;
    items.tex_s   = '0;
    items.tex_t   = '0;
    items.pos_x   = '0;
    items.pos_y   = '0;
    items.pos_z   = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Order, count, range errors and both winding rules.
    write_config(make_cfg(65535, 65535, 262143, 32768, 32768, 5));
    send_word(vtx(0, 0, 0, 0, 0, 0, 0));
    send_word(hdr(0));
    send_word(hdr(-32768));
    send_word(hdr(2));
    send_word(hdr(4));
    send_word(vtx(0, 0, -32768, 32767, 0, 0, 0));
    send_word(vtx(32767, 32767, 32767, -32768, 8388607, 8388607, 8388607));
    send_word(vtx(1, 1, 0, 0, -8388608, 8388607, 0));
    send_word(vtx(2, 2, 100, -100, 100, -100, 50));
    send_word(hdr(-5));
    send_word(vtx(5, 3, 1, 1, 0, 0, 0));
    send_word(vtx(6, 3, 1, 1, 256, 0, 0));
    send_word(vtx(7, 3, 1, 1, 0, 256, 0));
    // Lies on the line through the pivot and the previous vertex.
    send_word(vtx(8, 3, 1, 1, 0, 512, 0));
    // Reuses the pivot's source index.
    send_word(vtx(5, 3, 1, 1, 77, 33, 1));
    send_word(hdr(0));
    send_word(hdr(4));
    send_word(hdr(3));
    send_word(hdr(3));
    send_word(vtx(-1, 0, 0, 0, 0, 0, 0));
    send_word(hdr(3));
    send_word(vtx(0, -32768, 0, 0, 0, 0, 0));
    settle();

    // Command, vertex and index limits, and an index equal to the count.
    write_config(make_cfg(1, 4, 5, 4, 4, 0));
    send_word(hdr(3));
    send_word(vtx(0, 0, 0, 0, 10, 0, 0));
    send_word(vtx(1, 1, 0, 0, 0, 10, 0));
    send_word(vtx(2, 2, 0, 0, 0, 0, 10));
    send_word(hdr(3));
    send_word(hdr(5));
    send_word(hdr(-4));
    send_word(hdr(3));
    send_word(vtx(4, 0, 0, 0, 0, 0, 0));
    settle();

    run_phase(make_cfg(65535, 65535, 262143, 32768, 32768, 12), 0, 0, 380, 12, 1'b0);
    run_phase(make_cfg(4, 40, 60, 16, 8, 9), 58, 0, 250, 9, 1'b0);
    run_phase(make_cfg(65535, 65535, 262143, 3, 1, 5), 0, 58, 250, 5, 1'b1);
    run_phase(make_cfg(2, 7, 9, 32768, 32768, 3), 21, 21, 200, 3, 1'b0);
    run_phase(make_cfg(0, 0, 0, 0, 0, 0), 0, 0, 40, 3, 1'b0);
    run_phase(make_cfg(65535, 65535, 262143, 65535, 65535, 131071), 21, 21, 150, 8, 1'b0);

    if (mismatches == 0 && pending == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/sfa_pkg.sv
src/sfa_if.sv
src/sfa_cfg.sv
src/sfa_ctrl.sv
src/sfa_cross.sv
src/strip_fan_triangle_assembler.sv
src/sfa_checker.sv
bench/sfa_assembly_checker.sv
bench/tb_strip_fan_triangle_assembler.sv
